// File: src/triangle_fragment_depth_test_unit_defines.svh
// ----------------------------------------------------------------------------
// triangle fragment depth test defines
// assertion macros for the rtl of the depth test block
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FRAGMENT_DEPTH_TEST_UNIT_DEFINES_SVH
`define TRIANGLE_FRAGMENT_DEPTH_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset masking
`define TFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge
`define TFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFD_ASSERT(lbl, clk, rst, prop, msg)
`define TFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// types and constants of the triangle fragment depth test
// ----------------------------------------------------------------------------
package tfd_pkg;
   localparam int NUM_W   = 64;   // divider numerator width
   localparam int DEN_W   = 50;   // divider denominator width
   localparam int QUO_W   = 48;   // divider quotient width
   localparam int CNT_W   = 6;
   localparam int DEPTH_W = 24;
   localparam int WGT_W   = 17;
   localparam int EDGE_W  = 35;
   localparam int REQ_W   = 184;
   localparam int RSP_W   = 96;
   localparam logic [CNT_W-1:0] Q_BARY  = 6'd17;
   localparam logic [CNT_W-1:0] Q_RECIP = 6'd48;
   localparam logic [CNT_W-1:0] Q_DEPTH = 6'd25;
   localparam logic [CNT_W-1:0] Q_WGT   = 6'd17;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'hFFFFFF;

   typedef enum logic [3:0] {
      DOP_BA  = 4'd0,
      DOP_BB  = 4'd1,
      DOP_RA  = 4'd2,
      DOP_RB  = 4'd3,
      DOP_RC  = 4'd4,
      DOP_DEP = 4'd5,
      DOP_GA  = 4'd6,
      DOP_GB  = 4'd7,
      DOP_GC  = 4'd8
   } div_op_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] q_bits;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } div_sts_type;
endpackage

// File: src/tfd_div.sv
// ----------------------------------------------------------------------------
// tfd_div
// shared restoring divider, one quotient bit per cycle, quotient bit count
// set per operation; flags quotients that need more bits than requested
// ----------------------------------------------------------------------------
module tfd_div import tfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output div_sts_type       sts,
   output logic [QUO_W-1:0]  quot
);
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] bits_ff, bits_in;
   logic [QUO_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [NUM_W-1:0] head;
   logic [DEN_W:0]   trial;

   assign head  = num >> ctl.q_bits;
   assign trial = {rem_ff, bits_ff[NUM_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = head[DEN_W-1:0];
         bits_in = num << (7'(NUM_W) - 7'(ctl.q_bits));
         quot_in = '0;
         cnt_in  = ctl.q_bits;
         busy_in = 1'b1;
         ovf_in  = head >= NUM_W'(den);
      end else if (busy_ff) begin
         bits_in = {bits_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            rem_in  = DEN_W'(trial - {1'b0, den});
            quot_in = {quot_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      ovf_ff  <= ovf_in;
   end

   assign sts.done = done_ff;
   assign sts.ovf  = ovf_ff;
   assign quot     = quot_ff;
endmodule

// File: src/triangle_fragment_depth_test_unit.sv
// ----------------------------------------------------------------------------
// triangle_fragment_depth_test_unit
// pixel coverage by edge functions, perspective-correct weights and depth,
// depth test against an on-chip depth store
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req_    | in  | tuser: command; tdata: pixel and triangle
//  rsp_    | out | tdata: coverage, pass, index, weights, depth
//
//  a covered fragment in the frame goes from transfer to result through the
//  edge products on one multiplier, a setup step, then nine divisions through
//  one bit-serial divider, of 17, 17, 48, 48, 48, 25, 17, 17 and 17 quotient
//  bits, and then the depth read and write; an uncovered one ends after setup,
//  a covered one outside the frame skips the depth read and write
//  a clear writes zero to every store entry, one entry a cycle; the same
//  sweep runs after reset before the first item is taken
//  one item at a time: req_tready is low until the result is transferred
`include "triangle_fragment_depth_test_unit_defines.svh"
module triangle_fragment_depth_test_unit import tfd_pkg::*; #(
   parameter int WIDTH  = 256,
   parameter int HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,   // command
   // pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
   // vert_c_y, vert_a_w, vert_b_w, vert_c_w
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // covered, depth_pass, frame_index, weight_a, weight_b, weight_c,
   // frag_depth, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);
   localparam int STORE = WIDTH * HEIGHT;
   localparam int AW    = $clog2(STORE);
   localparam int IW    = (AW > 16) ? AW : 16;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_EDGE  = 7'b0000100,
      S_SETUP = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_MEMRD = 7'b0100000,
      S_CMP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;

   logic [AW-1:0]  clr_ff, clr_in;
   logic           clr_cmd_ff, clr_cmd_in;
   logic [2:0]     cnt_ff, cnt_in;
   div_op_type     op_ff, op_in;
   logic           start_ff, start_in;

   logic [7:0]          col_ff, row_ff;
   logic signed [15:0]  vx_ff [3];
   logic signed [15:0]  vy_ff [3];
   logic [23:0]         w_ff [3];
   logic signed [33:0]  prod_ff, acc_ff;
   logic signed [EDGE_W-1:0] edge_ff [3];
   logic [36:0]         s_ff;
   logic [16:0]         ba_ff, bb_ff;
   logic [QUO_W-1:0]    ra_ff, rb_ff, rc_ff;
   logic                in_frame_ff;

   logic                covered_ff, pass_ff;
   logic [IW-1:0]       idx_ff;
   logic [WGT_W-1:0]    ga_ff, gb_ff, gc_ff;
   logic [DEPTH_W-1:0]  depth_ff;

   logic [DEPTH_W-1:0]  mem [STORE];
   logic [DEPTH_W-1:0]  rd_data_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [DEPTH_W-1:0]  mem_wdata;

   logic signed [16:0]  sx, sy, m_a, m_b;
   logic [16:0]         bc;
   logic [DEN_W-1:0]    rsum;
   logic [31:0]         idx_full;
   logic                accept;
   logic                pass_now;

   div_ctl_type         div_ctl;
   div_sts_type         div_sts;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [QUO_W-1:0]    div_quot;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !done_ff;
   assign rsp_tvalid = done_ff;
   assign rsp_tdata  = {3'b000, depth_ff, gc_ff, gb_ff, ga_ff, idx_ff[15:0],
                        pass_ff, covered_ff};

   assign sx = $signed({5'b0, col_ff, 4'h8});
   assign sy = $signed({5'b0, row_ff, 4'h8});

   // one multiplier, operands stepped per cycle
   always_comb begin
      m_a = '0;
      m_b = '0;
      unique case (cnt_ff)
         3'd0: begin m_a = 17'(vx_ff[1]) - 17'(vx_ff[0]); m_b = sy - 17'(vy_ff[0]); end
         3'd1: begin m_a = 17'(vy_ff[1]) - 17'(vy_ff[0]); m_b = sx - 17'(vx_ff[0]); end
         3'd2: begin m_a = 17'(vx_ff[2]) - 17'(vx_ff[1]); m_b = sy - 17'(vy_ff[1]); end
         3'd3: begin m_a = 17'(vy_ff[2]) - 17'(vy_ff[1]); m_b = sx - 17'(vx_ff[1]); end
         3'd4: begin m_a = 17'(vx_ff[0]) - 17'(vx_ff[2]); m_b = sy - 17'(vy_ff[2]); end
         3'd5: begin m_a = 17'(vy_ff[0]) - 17'(vy_ff[2]); m_b = sx - 17'(vx_ff[2]); end
         default: begin m_a = '0; m_b = '0; end
      endcase
   end

   assign bc   = ((18'(ba_ff) + 18'(bb_ff)) >= 18'd65536) ? 17'd0
               : 17'(18'd65536 - 18'(ba_ff) - 18'(bb_ff));
   assign rsum = DEN_W'(ra_ff) + DEN_W'(rb_ff) + DEN_W'(rc_ff);
   assign idx_full = (32'(HEIGHT - 1) - 32'(row_ff)) * 32'(WIDTH) + 32'(col_ff);

   always_comb begin
      div_ctl.start  = start_ff;
      div_num = '0;
      div_den = rsum;
      div_ctl.q_bits = Q_WGT;
      unique case (op_ff)
         DOP_BA: begin
            div_num = NUM_W'(unsigned'(edge_ff[1])) << 16;
            div_den = DEN_W'(s_ff);
            div_ctl.q_bits = Q_BARY;
         end
         DOP_BB: begin
            div_num = NUM_W'(unsigned'(edge_ff[2])) << 16;
            div_den = DEN_W'(s_ff);
            div_ctl.q_bits = Q_BARY;
         end
         DOP_RA: begin
            div_num = NUM_W'(ba_ff) << 31;
            div_den = DEN_W'(w_ff[0]);
            div_ctl.q_bits = Q_RECIP;
         end
         DOP_RB: begin
            div_num = NUM_W'(bb_ff) << 31;
            div_den = DEN_W'(w_ff[1]);
            div_ctl.q_bits = Q_RECIP;
         end
         DOP_RC: begin
            div_num = NUM_W'(bc) << 31;
            div_den = DEN_W'(w_ff[2]);
            div_ctl.q_bits = Q_RECIP;
         end
         DOP_DEP: begin
            div_num = NUM_W'(1) << 47;
            div_ctl.q_bits = Q_DEPTH;
         end
         DOP_GA: div_num = NUM_W'(ra_ff) << 16;
         DOP_GB: div_num = NUM_W'(rb_ff) << 16;
         DOP_GC: div_num = NUM_W'(rc_ff) << 16;
         default: div_num = '0;
      endcase
   end

   tfd_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   assign pass_now  = (state_ff == S_CMP) && (depth_ff > rd_data_ff);
   assign mem_we    = (state_ff == S_CLEAR) || pass_now;
   assign mem_addr  = (state_ff == S_CLEAR) ? clr_ff : idx_ff[AW-1:0];
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : depth_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      state_in   = state_ff;
      done_in    = done_ff;
      clr_in     = clr_ff;
      clr_cmd_in = clr_cmd_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      start_in   = 1'b0;
      if (done_ff && rsp_tready) begin
         done_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(STORE - 1)) begin
               clr_in   = '0;
               state_in = S_IDLE;
               done_in  = clr_cmd_ff;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               clr_cmd_in = req_tuser;
               state_in   = req_tuser ? S_CLEAR : S_EDGE;
            end
         end
         S_EDGE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd6) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (edge_ff[0] > 0 && edge_ff[1] > 0 && edge_ff[2] > 0) begin
               op_in    = DOP_BA;
               start_in = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               if (op_ff == DOP_GC) begin
                  if (in_frame_ff) begin
                     state_in = S_MEMRD;
                  end else begin
                     state_in = S_IDLE;
                     done_in  = 1'b1;
                  end
               end else begin
                  op_in    = div_op_type'(op_ff + 1'b1);
                  start_in = 1'b1;
               end
            end
         end
         S_MEMRD: state_in = S_CMP;
         S_CMP: begin
            state_in = S_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         done_ff    <= 1'b0;
         clr_ff     <= '0;
         clr_cmd_ff <= 1'b0;
         start_ff   <= 1'b0;
         cnt_ff     <= '0;
         op_ff      <= DOP_BA;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         clr_ff     <= clr_in;
         clr_cmd_ff <= clr_cmd_in;
         start_ff   <= start_in;
         cnt_ff     <= cnt_in;
         op_ff      <= op_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff   <= req_tdata[7:0];
         row_ff   <= req_tdata[15:8];
         vx_ff[0] <= req_tdata[31:16];
         vy_ff[0] <= req_tdata[47:32];
         vx_ff[1] <= req_tdata[63:48];
         vy_ff[1] <= req_tdata[79:64];
         vx_ff[2] <= req_tdata[95:80];
         vy_ff[2] <= req_tdata[111:96];
         // a zero w counts as one
         w_ff[0]  <= (req_tdata[135:112] == '0) ? 24'd1 : req_tdata[135:112];
         w_ff[1]  <= (req_tdata[159:136] == '0) ? 24'd1 : req_tdata[159:136];
         w_ff[2]  <= (req_tdata[183:160] == '0) ? 24'd1 : req_tdata[183:160];
         covered_ff <= 1'b0;
         pass_ff    <= 1'b0;
         idx_ff     <= '0;
         ga_ff      <= '0;
         gb_ff      <= '0;
         gc_ff      <= '0;
         depth_ff   <= '0;
      end
      if (state_ff == S_EDGE) begin
         prod_ff <= m_a * m_b;
         if (cnt_ff[0]) begin
            acc_ff <= prod_ff;
         end else if (cnt_ff != 3'd0) begin
            edge_ff[2'(cnt_ff[2:1] - 2'd1)] <= EDGE_W'(acc_ff) - EDGE_W'(prod_ff);
         end
      end
      if (state_ff == S_SETUP) begin
         s_ff        <= 37'(unsigned'(edge_ff[0])) + 37'(unsigned'(edge_ff[1]))
                      + 37'(unsigned'(edge_ff[2]));
         in_frame_ff <= (32'(col_ff) < 32'(WIDTH)) && (32'(row_ff) < 32'(HEIGHT));
         covered_ff  <= edge_ff[0] > 0 && edge_ff[1] > 0 && edge_ff[2] > 0;
         if ((32'(col_ff) < 32'(WIDTH)) && (32'(row_ff) < 32'(HEIGHT))) begin
            idx_ff <= IW'(idx_full);
         end
      end
      if (state_ff == S_DIV && div_sts.done) begin
         unique case (op_ff)
            DOP_BA:  ba_ff <= div_quot[16:0];
            DOP_BB:  bb_ff <= div_quot[16:0];
            DOP_RA:  ra_ff <= div_quot;
            DOP_RB:  rb_ff <= div_quot;
            DOP_RC:  rc_ff <= div_quot;
            DOP_DEP: depth_ff <= (div_sts.ovf || div_quot[QUO_W-1:DEPTH_W] != '0)
                                 ? DEPTH_MAX : div_quot[DEPTH_W-1:0];
            DOP_GA:  ga_ff <= div_quot[WGT_W-1:0];
            DOP_GB:  gb_ff <= div_quot[WGT_W-1:0];
            DOP_GC:  gc_ff <= div_quot[WGT_W-1:0];
            default: ga_ff <= ga_ff;
         endcase
      end
      if (state_ff == S_CMP) begin
         pass_ff <= pass_now;
      end
   end

   `TFD_ASSERT(a_busy_no_take, clock, reset, rsp_tvalid |-> !req_tready, "ready while result waits")
   `TFD_ASSERT(a_pass_covered, clock, reset, (rsp_tvalid && pass_ff) |-> covered_ff, "pass without coverage")
   `TFD_ASSERT(a_uncov_zero, clock, reset, (rsp_tvalid && !covered_ff) |-> (depth_ff == '0), "depth on uncovered pixel")
   `TFD_ASSERT(a_write_src, clock, reset, pass_now |-> (in_frame_ff && covered_ff), "store write outside frame")
endmodule

// File: verif/triangle_fragment_depth_test_unit_tb.sv
// ----------------------------------------------------------------------------
// triangle_fragment_depth_test_unit_tb
// self-checking bench: fragments and depth store clears are driven over the
// request stream, and each response is compared with a behavioral
// predictor that keeps its own copy of the depth store
// ----------------------------------------------------------------------------
module triangle_fragment_depth_test_unit_tb import tfd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB_W     = 256;
   localparam int FB_H     = 256;
   localparam int WDOG_MAX = 300000;
   localparam int DRAIN    = 400;
   localparam bit CMD_TEST  = 1'b0;
   localparam bit CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic [23:0] depth;
      logic [16:0] wc;
      logic [16:0] wb;
      logic [16:0] wa;
      logic [15:0] index;
      logic        pass;
      logic        covered;
   } frag_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic             req_tuser = 1'b0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [DEPTH_W-1:0] depth_mirror [FB_W*FB_H];
   frag_result_type    expected_q [$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 hold_req = 1'b0;
   int                 stall_left = 0;
   logic [7:0]         pix_pool_x [16];
   logic [7:0]         pix_pool_y [16];

   triangle_fragment_depth_test_unit #(.WIDTH(FB_W), .HEIGHT(FB_H)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint edge_fn(longint px, longint py, longint qx, longint qy,
                                      longint sx, longint sy);
      return (qx - px) * (sy - py) - (qy - py) * (sx - px);
   endfunction

   function automatic frag_result_type shade_fragment(bit cmd, logic [REQ_W-1:0] d);
      frag_result_type res;
      longint sx, sy, ax, ay, bx, by, cx, cy, e_ab, e_bc, e_ca;
      longint unsigned wa, wb, wc, s, ba, bb, bc, ra, rb, rc, r, dep, ga, gb, gc;
      int col, row, idx;
      res = '0;
      if (cmd == CMD_CLEAR) begin
         foreach (depth_mirror[i]) depth_mirror[i] = '0;
         return res;
      end
      col = d[7:0];
      row = d[15:8];
      ax = sx16(d[31:16]);  ay = sx16(d[47:32]);
      bx = sx16(d[63:48]);  by = sx16(d[79:64]);
      cx = sx16(d[95:80]);  cy = sx16(d[111:96]);
      wa = d[135:112];  wb = d[159:136];  wc = d[183:160];
      if (wa == 0) wa = 1;
      if (wb == 0) wb = 1;
      if (wc == 0) wc = 1;
      sx = col * 16 + 8;
      sy = row * 16 + 8;
      e_ab = edge_fn(ax, ay, bx, by, sx, sy);
      e_bc = edge_fn(bx, by, cx, cy, sx, sy);
      e_ca = edge_fn(cx, cy, ax, ay, sx, sy);
      res.covered = e_ab > 0 && e_bc > 0 && e_ca > 0;
      idx = (FB_H - 1 - row) * FB_W + col;
      res.index = idx[15:0];
      if (res.covered) begin
         s  = e_ab + e_bc + e_ca;
         ba = (longint'(e_bc) << 16) / s;
         bb = (longint'(e_ca) << 16) / s;
         bc = (ba + bb >= 65536) ? 0 : 65536 - ba - bb;
         ra = (ba << 31) / wa;
         rb = (bb << 31) / wb;
         rc = (bc << 31) / wc;
         r  = ra + rb + rc;
         dep = 0; ga = 0; gb = 0; gc = 0;
         if (r != 0) begin
            dep = (64'd1 << 47) / r;
            if (dep > DEPTH_MAX) dep = DEPTH_MAX;
            ga = (ra << 16) / r;
            gb = (rb << 16) / r;
            gc = (rc << 16) / r;
            if (ga > 65536) ga = 65536;
            if (gb > 65536) gb = 65536;
            if (gc > 65536) gc = 65536;
         end
         res.wa = ga[16:0];
         res.wb = gb[16:0];
         res.wc = gc[16:0];
         res.depth = dep[23:0];
         if (dep[23:0] > depth_mirror[idx]) begin
            depth_mirror[idx] = dep[23:0];
            res.pass = 1'b1;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [REQ_W-1:0] rand_req();
      return REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
   endfunction

   task automatic send_item(bit cmd, logic [REQ_W-1:0] d);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      expected_q.insert(expected_q.size(), shade_fragment(cmd, d));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= rand_req();
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [REQ_W-1:0] pack_req(logic [7:0] px, logic [7:0] py,
      logic [15:0] ax, logic [15:0] ay, logic [15:0] bx, logic [15:0] by,
      logic [15:0] cx, logic [15:0] cy, logic [23:0] wa, logic [23:0] wb,
      logic [23:0] wc);
      return {wc, wb, wa, cy, cx, by, bx, ay, ax, py, px};
   endfunction

   function automatic logic [23:0] rand_w();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 24'd0;
      if (p < 4) return 24'($urandom_range(1, 24'h1FFFF));
      if (p < 7) return 24'($urandom_range(24'h8000, 24'h40000));
      return 24'($urandom);
   endfunction

   // triangle around the pixel centre; counterclockwise unless flipped
   function automatic logic [REQ_W-1:0] make_tri(logic [7:0] px, logic [7:0] py, int span,
                                                 bit flip);
      int ccx, ccy;
      logic [15:0] ax, ay, bx, by, cx, cy;
      ccx = px * 16 + 8;
      ccy = py * 16 + 8;
      ax = 16'(ccx - $urandom_range(1, span));  ay = 16'(ccy - $urandom_range(1, span));
      bx = 16'(ccx + $urandom_range(1, span));  by = 16'(ccy - $urandom_range(1, span));
      cx = 16'(ccx + $urandom_range(0, span) - span / 2);
      cy = 16'(ccy + $urandom_range(1, span));
      if (flip)
         return pack_req(px, py, ax, ay, cx, cy, bx, by, rand_w(), rand_w(), rand_w());
      return pack_req(px, py, ax, ay, bx, by, cx, cy, rand_w(), rand_w(), rand_w());
   endfunction

   // ---------------------------------------------------------------- response side
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req <= 1'b0;
         stall_left <= 3000;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                   : $urandom_range(0, 3);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      frag_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(frag_result_type)-1:0];
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", longint'(rsp_tdata[63:0]), 64'd0);
         end else begin
            want = expected_q.pop_front();
            if (got.covered !== want.covered)
               report_mismatch("covered", 64'(got.covered), 64'(want.covered));
            if (got.pass !== want.pass)
               report_mismatch("depth_pass", 64'(got.pass), 64'(want.pass));
            if (got.index !== want.index)
               report_mismatch("frame_index", 64'(got.index), 64'(want.index));
            if (got.wa !== want.wa)
               report_mismatch("weight_a", 64'(got.wa), 64'(want.wa));
            if (got.wb !== want.wb)
               report_mismatch("weight_b", 64'(got.wb), 64'(want.wb));
            if (got.wc !== want.wc)
               report_mismatch("weight_c", 64'(got.wc), 64'(want.wc));
            if (got.depth !== want.depth)
               report_mismatch("frag_depth", 64'(got.depth), 64'(want.depth));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
         $display("[triangle_fragment_depth_test_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      // corners of the frame and the coordinate range
      send_item(CMD_TEST, pack_req(8'd0, 8'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                                   16'h0000, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      send_item(CMD_TEST, pack_req(8'd255, 8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                                   16'h0000, 16'h7FFF, 24'd1, 24'd1, 24'd1));
      // zero w taken as one
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd0, 16'd400, 16'd0,
                                   16'd168, 16'd400, 24'd0, 24'd0, 24'd0));
      // same pixel again with a higher depth, then a lower one
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd0, 16'd400, 16'd0,
                                   16'd168, 16'd400, 24'h010000, 24'h010000, 24'h010000));
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd0, 16'd400, 16'd0,
                                   16'd168, 16'd400, 24'h000100, 24'h000200, 24'h000300));
      // zero area: collinear and all points equal
      send_item(CMD_TEST, pack_req(8'd5, 8'd5, 16'd0, 16'd0, 16'd88, 16'd88,
                                   16'd200, 16'd200, 24'h010000, 24'h010000, 24'h010000));
      send_item(CMD_TEST, pack_req(8'd5, 8'd5, 16'd88, 16'd88, 16'd88, 16'd88,
                                   16'd88, 16'd88, 24'h010000, 24'h010000, 24'h010000));
      // clockwise triangle and centre on an edge
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd0, 16'd168, 16'd400,
                                   16'd400, 16'd0, 24'h010000, 24'h010000, 24'h010000));
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd168, 16'd400, 16'd168,
                                   16'd168, 16'd400, 24'h010000, 24'h010000, 24'h010000));
      // tiny triangle just around the centre, extreme w spread
      send_item(CMD_TEST, pack_req(8'd128, 8'd64, 16'd2055, 16'd1031, 16'd2057, 16'd1031,
                                   16'd2056, 16'd1033, 24'd1, 24'hFFFFFF, 24'h000800));
      for (int i = 0; i < 6; i++)
         send_item(CMD_TEST, make_tri(8'($urandom), 8'($urandom), 64, i[0]));
      // clear, then the earlier pixel passes again
      send_item(CMD_CLEAR, '0);
      send_item(CMD_CLEAR, rand_req());
      send_item(CMD_TEST, pack_req(8'd10, 8'd10, 16'd0, 16'd0, 16'd400, 16'd0,
                                   16'd168, 16'd400, 24'h010000, 24'h010000, 24'h010000));
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      for (int i = 0; i < 6; i++)
         send_item(CMD_TEST, make_tri(pix_pool_x[i], pix_pool_y[i], 200, 1'b0));
   endtask

   task automatic test_random(int count);
      int p, k;
      logic [REQ_W-1:0] d;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(0, 99);
         k = $urandom_range(0, 15);
         if (p < 15) begin
            d = rand_req();
         end else if (p < 60) begin
            d = make_tri(pix_pool_x[k], pix_pool_y[k], $urandom_range(4, 300),
                         $urandom_range(0, 9) == 0);
         end else if (p < 90) begin
            d = make_tri(8'($urandom), 8'($urandom), $urandom_range(4, 80),
                         $urandom_range(0, 7) == 0);
         end else begin
            d = make_tri(8'($urandom), 8'($urandom), $urandom_range(300, 3000), 1'b0);
         end
         send_item(CMD_TEST, d);
         if (i == count / 2) send_item(CMD_CLEAR, '0);
      end
   endtask

   initial begin
      foreach (depth_mirror[i]) depth_mirror[i] = '0;
      foreach (pix_pool_x[i]) begin
         pix_pool_x[i] = 8'($urandom);
         pix_pool_y[i] = 8'($urandom);
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(1650);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("[triangle_fragment_depth_test_unit] OK");
      else
         $display("[triangle_fragment_depth_test_unit] ERROR");
      $finish;
   end
endmodule
